// ===== hdl/stacked_boxcar_waveform_assert.svh =====
// Assertion macros for the stacked boxcar waveform RTL.
// Depends on nothing; included by stacked_boxcar_waveform, the module that carries assertions.
`ifndef STACKED_BOXCAR_WAVEFORM_ASSERT_SVH
`define STACKED_BOXCAR_WAVEFORM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbw_pkg.sv =====
// Types and constants for the stacked boxcar waveform generator.
// Used by sbw_accum, stacked_boxcar_waveform and the testbench; depends on nothing.
package sbw_pkg;

  localparam int TIME_W   = 48;
  localparam int INDEX_W  = 4;
  localparam int FRAC_W   = 16;
  localparam int HEIGHT_W = 32;
  localparam int OUT_W    = 36;
  localparam int RATE_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int PHASE_W  = 32;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Input item kinds (carried on tuser).
  localparam logic CMD_EVAL  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_RATE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 1'd1;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd0;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // One pulse entry as it is kept in the table memory.
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [FRAC_W-1:0]   width;
    logic [FRAC_W-1:0]   delay;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controls from the sequencer to the accumulator.
  typedef struct packed {
    logic capture;    // take the time of a new evaluate item, clear the sum
    logic load_phase; // register the phase from the product
    logic step;       // fold the entry on the memory read port into the sum
  } acc_ctl_t;

endpackage

// ===== hdl/sbw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing; holds the pulse table of the waveform generator.
module sbw_ram #(
  parameter int  WIDTH = 64,
  parameter int  DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AddrW-1:0]             waddr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         re,
  input  logic [AddrW-1:0]             raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sbw_accum.sv =====
// Phase computation and saturating window accumulator.
// Depends on sbw_pkg; driven by the sequencer in stacked_boxcar_waveform.
module sbw_accum #(
  parameter int PHASE_BITS = 16
) (
  input  logic                          clk,
  input  sbw_pkg::acc_ctl_t             ctl,
  input  logic [sbw_pkg::PHASE_W-1:0]   time_lo,
  input  logic [sbw_pkg::RATE_W-1:0]    cycle_rate,
  input  sbw_pkg::entry_t               entry,
  output logic [sbw_pkg::OUT_W-1:0]     sum
);

  localparam int PW = sbw_pkg::PHASE_W;
  localparam int OW = sbw_pkg::OUT_W;
  localparam int FW = sbw_pkg::FRAC_W;
  localparam int HW = sbw_pkg::HEIGHT_W;
  // Phase truncated to its top PHASE_BITS bits.
  localparam logic [PW-1:0] PhaseKeep = ~((PW'(1) << (PW - PHASE_BITS)) - PW'(1));

  logic [PW-1:0] time_r;
  logic [PW-1:0] phase_r;
  logic [OW-1:0] sum_r;
  logic [OW-1:0] sum_nxt;
  logic [PW-1:0] prod_lo;
  logic [PW-1:0] on_edge;
  logic [PW:0]   off_edge;
  logic          hit;
  logic [OW:0]   add_full;

  // Only the fractional cycle matters, so the low word of the product suffices.
  assign prod_lo = time_r * cycle_rate;

  assign on_edge  = {entry.delay, {(PW-FW){1'b0}}};
  assign off_edge = {1'b0, on_edge} + {1'b0, entry.width, {(PW-FW){1'b0}}};

  always_comb begin
    if (off_edge[PW]) begin
      hit = (phase_r < off_edge[PW-1:0]) || (phase_r > on_edge);
    end else begin
      hit = (phase_r > on_edge) && (phase_r < off_edge[PW-1:0]);
    end
  end

  assign add_full = {sum_r[OW-1], sum_r} + {{(OW+1-HW){entry.height[HW-1]}}, entry.height};

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.capture) begin
      sum_nxt = '0;
    end else if (ctl.step && hit) begin
      if (add_full[OW] != add_full[OW-1]) begin
        sum_nxt = add_full[OW] ? sbw_pkg::OUT_MIN : sbw_pkg::OUT_MAX;
      end else begin
        sum_nxt = add_full[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      time_r <= time_lo;
    end
    if (ctl.load_phase) begin
      phase_r <= prod_lo & PhaseKeep;
    end
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

// ===== hdl/stacked_boxcar_waveform.sv =====
// Stacked boxcar waveform generator: a write item loads one table entry when it is accepted.
// An evaluate item runs in steps from acceptance to its result: the phase multiply and first
// table read, then one step per active entry (min(active_count, MAX_ENTRIES)) to fold it into
// the sum, then posting the result; a result still held on the output stalls the posting step.
// The next item is taken in the cycle the result appears. Reset (synchronous, rst_n low)
// restores cycle_rate and active_count; table contents are kept until written.
module stacked_boxcar_waveform #(
  parameter int MAX_ENTRIES = 16,
  parameter int PHASE_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // time_value[47:0], entry_index[51:48], entry_delay[67:52],
  // entry_width[83:68], entry_height[115:84], zero[119:116]
  input  logic [sbw_pkg::IN_DATA_W-1:0]    in_tdata,
  // command[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // drive_value[35:0], zero[39:36]
  output logic [sbw_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "stacked_boxcar_waveform_assert.svh"

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (AW > sbw_pkg::INDEX_W) ? AW : sbw_pkg::INDEX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [CW-1:0]                 idx_inc;
  logic [sbw_pkg::RATE_W-1:0]    cycle_rate_r;
  logic [sbw_pkg::COUNT_W-1:0]   active_count_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [sbw_pkg::OUT_W-1:0]     out_data_r;
  logic                          in_acc, eval_acc, wr_acc;
  logic                          post;
  logic [XW-1:0]                 idx_ext;
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_raddr;
  sbw_pkg::entry_t               wr_entry, rd_entry;
  logic [sbw_pkg::ENTRY_W-1:0]   rd_bits;
  sbw_pkg::acc_ctl_t             acc_ctl;
  logic [sbw_pkg::OUT_W-1:0]     acc_sum;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign eval_acc  = in_acc && (in_tuser == sbw_pkg::CMD_EVAL);
  assign wr_acc    = in_acc && (in_tuser == sbw_pkg::CMD_WRITE);
  assign idx_inc   = idx_r + CW'(1);
  assign post      = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_rate_r   <= sbw_pkg::RATE_RESET;
      active_count_r <= sbw_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbw_pkg::CFG_CYCLE_RATE:   cycle_rate_r   <= cfg_data;
        sbw_pkg::CFG_ACTIVE_COUNT: active_count_r <= cfg_data[sbw_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Table writes: indexes past the table are dropped.
  assign idx_ext  = XW'(in_tdata[51:48]);
  assign ram_we   = wr_acc && (32'(in_tdata[51:48]) < 32'(MAX_ENTRIES));
  assign wr_entry = '{height: in_tdata[115:84], width: in_tdata[83:68],
                      delay: in_tdata[67:52]};

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    acc_ctl       = '0;
    out_valid_nxt = out_valid_r;
    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (eval_acc) begin
          acc_ctl.capture = 1'b1;
          idx_nxt         = '0;
          cnt_nxt = (32'(active_count_r) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                            : CW'(active_count_r);
          state_nxt       = S_MUL;
        end
      end
      S_MUL: begin
        acc_ctl.load_phase = 1'b1;
        if (cnt_r != '0) begin
          ram_re    = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        acc_ctl.step = 1'b1;
        if (idx_inc == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          idx_nxt   = idx_inc;
        end
      end
      S_DONE: begin
        if (post) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    if (post) begin
      out_data_r <= acc_sum;
    end
  end

  sbw_ram #(
    .WIDTH (sbw_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_ext[AW-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );

  assign rd_entry = rd_bits;

  sbw_accum #(
    .PHASE_BITS (PHASE_BITS)
  ) u_accum (
    .clk        (clk),
    .ctl        (acc_ctl),
    .time_lo    (in_tdata[sbw_pkg::PHASE_W-1:0]),
    .cycle_rate (cycle_rate_r),
    .entry      (rd_entry),
    .sum        (acc_sum)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sbw_pkg::OUT_DATA_W-sbw_pkg::OUT_W){1'b0}}, out_data_r};

  `SBW_ASSERT_NOW(a_scan_in_range, clk, rst_n, (state_r == S_SCAN),
    (idx_r < cnt_r) && (cnt_r != '0), "scan index outside active entries")
  `SBW_ASSERT_NEXT(a_eval_starts, clk, rst_n, eval_acc,
    (state_r == S_MUL), "evaluate item did not start the phase step")
  `SBW_ASSERT_NEXT(a_write_one_cycle, clk, rst_n, wr_acc,
    (state_r == S_IDLE) && !out_valid_r || (state_r == S_IDLE),
    "write item left the sequencer busy")
  `SBW_ASSERT_NEXT(a_post_result, clk, rst_n, post,
    out_valid_r && (state_r == S_IDLE), "finished sum not posted")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the stacked boxcar waveform generator.
// Needs sbw_pkg and stacked_boxcar_waveform; it drives table writes and evaluations on
// the input stream and checks each drive value against its predictor or a directed value.
module tb;
  import sbw_pkg::*;

  localparam int     TABLE_DEPTH = 16;
  localparam int     PHASE_KEEP  = 16;
  localparam longint DRIVE_HI    = 64'sd34359738367;
  localparam longint DRIVE_LO    = -64'sd34359738368;
  localparam int     SETTLE      = 24;   // covers the longest evaluate, which scans all 16 entries

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // Fields of one input item, time in the lowest bits as on in_tdata.
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [FRAC_W-1:0]   width;
    logic [FRAC_W-1:0]   delay;
    logic [INDEX_W-1:0]  index;
    logic [TIME_W-1:0]   tval;
  } pulse_item_t;

  typedef struct {
    row_kind_t             kind;
    logic                  cmd;
    pulse_item_t           item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    typed;
    logic [OUT_W-1:0]      typed_val;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_tvalid    = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata     = '0;
  logic                  in_tuser     = CMD_EVAL;
  logic                  out_tvalid;
  logic                  out_tready   = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_CYCLE_RATE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Expected value that rides along with a directed item, when it has one.
  bit                    in_typed     = 1'b0;
  logic [OUT_W-1:0]      in_typed_val = '0;

  stacked_boxcar_waveform u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor state.
  logic [FRAC_W-1:0]   delay_tab  [TABLE_DEPTH];
  logic [FRAC_W-1:0]   width_tab  [TABLE_DEPTH];
  logic [HEIGHT_W-1:0] height_tab [TABLE_DEPTH];
  logic [RATE_W-1:0]   model_rate  = RATE_RESET;
  logic [COUNT_W-1:0]  model_count = COUNT_RESET;

  logic [OUT_W-1:0] drive_q [$];
  int mismatches = 0;
  int n_items    = 0;
  int n_evals    = 0;
  int n_settings = 0;

  // Stall control shared by the two sides.
  bit tail_mode = 1'b0;
  bit tx_steady = 1'b0;
  int tx_calm   = 0;
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;
  int stall_left = 0;
  int rx_calm   = 0;

  stim_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("stacked_boxcar_waveform verification failed");
    $finish;
  end

  function automatic logic [OUT_W-1:0] predict_drive(input logic [TIME_W-1:0] t);
    logic [79:0]        prod;
    logic [32:0]        ph;
    logic [32:0]        on;
    logic [32:0]        off;
    logic [COUNT_W-1:0] n;
    bit                 hit;
    longint             acc;
    acc  = 0;
    prod = t * model_rate;
    ph   = {1'b0, prod[31:0] & (32'hFFFF_FFFF << (32 - PHASE_KEEP))};
    n    = (model_count > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : model_count;
    for (int i = 0; i < n; i++) begin
      on  = {1'b0, delay_tab[i], 16'h0};
      off = on + {1'b0, width_tab[i], 16'h0};
      // A window past the end of the cycle covers both ends of the phase range.
      if (!off[32]) hit = (ph > on) && (ph < off);
      else          hit = (ph < {1'b0, off[31:0]}) || (ph > on);
      if (hit) begin
        acc += longint'($signed(height_tab[i]));
        if (acc > DRIVE_HI) acc = DRIVE_HI;
        if (acc < DRIVE_LO) acc = DRIVE_LO;
      end
    end
    return acc[OUT_W-1:0];
  endfunction

  task automatic store_pulse(input pulse_item_t w);
    delay_tab[w.index]  = w.delay;
    width_tab[w.index]  = w.width;
    height_tab[w.index] = w.height;
  endtask

  task automatic note_mismatch(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected drive_value %h, got %h", what, want, got);
  endtask

  // Bookkeeping at each clock edge: configuration, table writes, expected and actual results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CYCLE_RATE) model_rate  = cfg_data;
        else                             model_count = cfg_data[COUNT_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_WRITE) store_pulse(in_tdata[$bits(pulse_item_t)-1:0]);
        else if (in_typed)         drive_q.push_back(in_typed_val);
        else                       drive_q.push_back(predict_drive(in_tdata[TIME_W-1:0]));
      end
      if (out_tvalid && out_tready) begin
        if (drive_q.size() == 0) begin
          note_mismatch("result with nothing pending", '0, out_tdata[OUT_W-1:0]);
        end else begin
          if (out_tdata[OUT_W-1:0] !== drive_q[0])
            note_mismatch("drive_value", drive_q[0], out_tdata[OUT_W-1:0]);
          void'(drive_q.pop_front());
          n_evals++;
        end
      end
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (tail_mode || rx_calm != 0) begin
      if (rx_calm != 0) rx_calm <= rx_calm - 1;
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      rx_calm    <= $urandom_range(20, 80);
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic cmd, input pulse_item_t it, input bit typed,
                           input logic [OUT_W-1:0] tv);
    if (tail_mode || tx_steady) begin
      tx_calm = 0;
    end else if (tx_calm > 0) begin
      tx_calm--;
    end else if ($urandom_range(0, 29) == 0) begin
      tx_calm = $urandom_range(20, 60);
    end else if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tuser     <= cmd;
    in_tdata     <= {{(IN_DATA_W - $bits(pulse_item_t)){1'b0}}, it};
    in_typed     <= typed;
    in_typed_val <= tv;
    do @(posedge clk); while (!in_tready);
    n_items++;
  endtask

  // Registers change only once every result is back and the block has had time to settle.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic stim_row_t eval_row(input logic [TIME_W-1:0] t, input bit typed,
                                         input logic [OUT_W-1:0] tv);
    stim_row_t r;
    r = '{ROW_ITEM, CMD_EVAL, '0, CFG_CYCLE_RATE, '0, typed, tv};
    r.item.tval  = t;
    r.item.index = 4'hA;   // unused by an evaluation
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [INDEX_W-1:0] idx,
                                          input logic [FRAC_W-1:0] d,
                                          input logic [FRAC_W-1:0] w,
                                          input logic [HEIGHT_W-1:0] h);
    stim_row_t r;
    r = '{ROW_ITEM, CMD_WRITE, '0, CFG_CYCLE_RATE, '0, 1'b0, '0};
    r.item = '{h, w, d, idx, 48'hDEAD_BEEF_1234};   // time is unused by a write
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '{ROW_CFG, CMD_EVAL, '0, idx, val, 1'b0, '0};
    return r;
  endfunction

  function automatic pulse_item_t random_pulse(input logic [INDEX_W-1:0] idx);
    pulse_item_t p;
    p.tval   = TIME_W'({$urandom, $urandom});
    p.index  = idx;
    p.delay  = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                            : 16'($urandom);
    p.width  = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                            : 16'($urandom);
    case ($urandom_range(0, 7))
      0:       p.height = 32'h8000_0000;
      1:       p.height = 32'h7FFF_FFFF;
      2:       p.height = 32'($signed($urandom_range(0, 200)) - 100);
      default: p.height = $urandom;
    endcase
    return p;
  endfunction

  initial begin
    pulse_item_t        it;
    logic [RATE_W-1:0]  rate;
    logic [COUNT_W-1:0] cnt;
    int                 j;

    // Count zero, boundary phases, rate of zero, time past many cycles, and wrapped windows.
    dir_rows.push_back(cfg_row(CFG_ACTIVE_COUNT, 32'd0));
    dir_rows.push_back(eval_row(48'h0, 1'b1, '0));
    dir_rows.push_back(eval_row(48'hFFFF_FFFF_FFFF, 1'b1, '0));
    dir_rows.push_back(write_row(4'd0, 16'h0000, 16'h8000, 32'h7FFF_FFFF));
    dir_rows.push_back(write_row(4'd1, 16'hFFFF, 16'hFFFF, 32'h8000_0000));
    dir_rows.push_back(write_row(4'd2, 16'h4000, 16'h4000, 32'h0000_0001));
    dir_rows.push_back(write_row(4'd3, 16'hC000, 16'h8000, 32'hFFFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_ACTIVE_COUNT, 32'd1));
    dir_rows.push_back(eval_row(48'h0, 1'b1, '0));
    dir_rows.push_back(eval_row(48'h8000, 1'b1, '0));
    dir_rows.push_back(eval_row(48'h4000, 1'b1, 36'h0_7FFF_FFFF));
    dir_rows.push_back(eval_row(48'hFFFF_FFFF_4000, 1'b1, 36'h0_7FFF_FFFF));
    dir_rows.push_back(cfg_row(CFG_CYCLE_RATE, 32'd0));
    dir_rows.push_back(eval_row(48'h4000, 1'b1, '0));
    dir_rows.push_back(cfg_row(CFG_ACTIVE_COUNT, 32'd4));
    dir_rows.push_back(cfg_row(CFG_CYCLE_RATE, 32'd65536));
    dir_rows.push_back(eval_row(48'h0, 1'b0, '0));
    dir_rows.push_back(eval_row(48'h4000, 1'b0, '0));
    dir_rows.push_back(eval_row(48'h7FFF, 1'b0, '0));
    dir_rows.push_back(eval_row(48'hFFFF, 1'b0, '0));
    dir_rows.push_back(eval_row(48'hC001, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_CYCLE_RATE, 32'hFFFF_FFFF));
    dir_rows.push_back(eval_row(48'hFFFF_FFFF_FFFF, 1'b0, '0));
    dir_rows.push_back(eval_row(48'h1, 1'b0, '0));
    dir_rows.push_back(cfg_row(CFG_CYCLE_RATE, 32'd1));
    dir_rows.push_back(eval_row(48'hFFFF_FFFF_FFFF, 1'b0, '0));
    dir_rows.push_back(eval_row(48'h8000_0000_0000, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) write_cfg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      else send_item(dir_rows[r].cmd, dir_rows[r].item, dir_rows[r].typed,
                     dir_rows[r].typed_val);
    end

    // Fill the whole table so that any entry count reads only written entries.
    for (int k = 0; k < TABLE_DEPTH; k++)
      send_item(CMD_WRITE, random_pulse(INDEX_W'(k)), 1'b0, '0);

    for (int ph = 0; ph < 20; ph++) begin
      tail_mode = (ph >= 17);
      case (ph)
        0, 3, 4: begin rate = 32'd65536;     cnt = 5'd16; end
        1:       begin rate = 32'hFFFF_FFFF; cnt = 5'd31; end
        2:       begin rate = 32'd1;         cnt = 5'd0;  end
        default: begin
          case ($urandom_range(0, 5))
            0:       rate = 32'd0;
            1, 2:    rate = 32'd65536;
            3:       rate = 32'($urandom_range(1, 1 << 20));
            default: rate = $urandom;
          endcase
          cnt = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
        end
      endcase
      write_cfg(CFG_CYCLE_RATE, rate);
      write_cfg(CFG_ACTIVE_COUNT, 32'(cnt));

      // Full-width windows with extreme heights drive the sum to its limits.
      if (ph == 0 || ph == 4) begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          it = random_pulse(INDEX_W'(k));
          it.delay  = 16'h0;
          it.width  = 16'hFFFF;
          it.height = (ph == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          send_item(CMD_WRITE, it, 1'b0, '0);
        end
      end

      tx_steady = (ph == 3);
      if (ph == 3) hold_req++;

      for (int n = 0; n < 60; n++) begin
        it = random_pulse(INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)));
        if ($urandom_range(0, 3) == 0) begin
          send_item(CMD_WRITE, it, 1'b0, '0);
        end else begin
          // Aim some evaluations exactly at window edges.
          if (model_rate == 32'd65536 && $urandom_range(0, 2) == 0) begin
            j = $urandom_range(0, TABLE_DEPTH - 1);
            it.tval[15:0] = $urandom_range(0, 1) ? delay_tab[j] : delay_tab[j] + width_tab[j];
          end
          send_item(CMD_EVAL, it, 1'b0, '0);
        end
      end
      tx_steady = 1'b0;
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
    repeat (SETTLE + 16) @(posedge clk);

    $display("Sent %0d items and checked %0d drive values over %0d register writes,",
             n_items, n_evals, n_settings);
    $display("with wrapped windows, edge phases, extreme rates and counts, and backpressure.");
    if (mismatches == 0) begin
      $display("stacked_boxcar_waveform verification clean");
    end else begin
      $display("stacked_boxcar_waveform verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sbw_pkg.sv
hdl/sbw_ram.sv
hdl/sbw_accum.sv
hdl/stacked_boxcar_waveform.sv
dv/tb.sv
